@@ hw/rtl/min_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// min_priority_queue_defines
// Assertion helpers used by the priority queue RTL.
// ----------------------------------------------------------------------------
// Each macro assumes a clock named clk and an active-high reset named rst.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define MPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg
// Widths, command codes and status codes of the min priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAPACITY_DEFAULT = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/mpq_ram.sv @@
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/mpq_cmp.sv @@
// ----------------------------------------------------------------------------
// mpq_cmp
// Shared signed key comparator used by the minimum search.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cmp (
  input  wire logic signed [mpq_pkg::KEY_W-1:0] cand,
  input  wire logic signed [mpq_pkg::KEY_W-1:0] best,
  output logic                                  less
);

  import mpq_pkg::*;

  // Strictly less, so that among equal keys the earliest one found is kept.
  assign less = cand < best;

endmodule

`default_nettype wire

@@ hw/rtl/min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_priority_queue
// Ascending priority queue of signed 32-bit keys held in a small RAM.
// ----------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction. An insert,
// an overflow or an underflow goes from idle straight to the finish state,
// which loads the output register once it is free and then returns to idle,
// where the next command can be accepted. A remove goes from idle through
// the scan state to the finish state and back to idle; in the scan state
// the sequencer reads the store one entry per cycle through the single RAM
// read port and runs every key through one shared comparator, then
// moves the last entry into the freed slot. The command side is not ready
// while a command is in progress; a finished result waits in the output
// register and the next command can be accepted meanwhile. If that result is
// still waiting when the next one is finished, the sequencer holds the new
// one until the output register frees. The store needs no initialization.
`default_nettype none
`include "min_priority_queue_defines.svh"

module min_priority_queue #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cmd_valid,
  output logic                                      cmd_ready,
  input  wire logic                                 cmd,
  input  wire logic signed [mpq_pkg::KEY_W-1:0]     value_in,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output logic signed      [mpq_pkg::KEY_W-1:0]     value_out,
  output logic             [mpq_pkg::STATUS_W-1:0]  status,
  output logic             [mpq_pkg::COUNT_W-1:0]   count,
  output logic                                      is_empty
);

  import mpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                state;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             rd_idx;
  logic                      data_vld;
  logic [CW-1:0]             data_idx;
  logic signed [KEY_W-1:0]   best_val;
  logic [AW-1:0]             best_idx;
  logic signed [KEY_W-1:0]   pend_val;
  logic [STATUS_W-1:0]       pend_status;

  logic                      cmd_fire;
  logic                      full;
  logic                      issue;
  logic                      scan_last;
  logic                      cand_less;
  logic                      take;
  logic signed [KEY_W-1:0]   new_best_val;
  logic [AW-1:0]             new_best_idx;
  logic                      out_free;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [KEY_W-1:0]          ram_wdata;
  logic [KEY_W-1:0]          ram_rdata;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign full      = (cnt == CW'(CAPACITY));
  assign issue     = (state == S_SCAN) && (rd_idx < cnt);
  assign out_free  = !res_valid || res_ready;

  mpq_cmp u_cmp (
    .cand (ram_rdata),
    .best (best_val),
    .less (cand_less)
  );

  // The first entry read always starts the running minimum.
  assign take         = (data_idx == '0) || cand_less;
  assign new_best_val = take ? $signed(ram_rdata) : best_val;
  assign new_best_idx = take ? data_idx[AW-1:0] : best_idx;
  assign scan_last    = (state == S_SCAN) && data_vld && (data_idx == cnt - CW'(1));

  // On the last read the entry in hand is the last one, and it fills the hole
  // left by the minimum. Entry order is not visible at the outputs.
  assign ram_we    = (cmd_fire && (cmd == CMD_INSERT) && !full) || scan_last;
  assign ram_waddr = scan_last ? new_best_idx : cnt[AW-1:0];
  assign ram_wdata = scan_last ? ram_rdata : value_in;

  mpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
      data_vld  <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          data_vld <= 1'b0;
          if (cmd_fire) begin
            if (cmd == CMD_INSERT) begin
              if (!full) begin
                cnt <= cnt + CW'(1);
              end
              state <= S_FINISH;
            end else if (cnt == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          data_vld <= issue;
          if (scan_last) begin
            cnt   <= cnt - CW'(1);
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rd_idx <= '0;
        if (cmd_fire) begin
          pend_val <= '0;
          if (cmd == CMD_INSERT) begin
            pend_status <= full ? ST_OVERFLOW : ST_INSERTED;
          end else begin
            pend_status <= ST_UNDERFLOW;
          end
        end
      end
      S_SCAN: begin
        data_idx <= rd_idx;
        if (issue) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (data_vld) begin
          best_val <= new_best_val;
          best_idx <= new_best_idx;
        end
        if (scan_last) begin
          pend_val    <= new_best_val;
          pend_status <= ST_REMOVED;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          value_out <= pend_val;
          status    <= pend_status;
          count     <= COUNT_W'(cnt);
          is_empty  <= (cnt == '0);
        end
      end
      default: begin
        rd_idx <= '0;
      end
    endcase
  end

  `MPQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CW'(CAPACITY), "entry count above capacity")
  `MPQ_ASSERT_IMP(a_scan_nonempty, state == S_SCAN, cnt != '0, "scan with empty store")
  `MPQ_ASSERT_NXT(a_busy_after_cmd, cmd_fire, !cmd_ready, "command accepted while busy")
  `MPQ_ASSERT_IMP(a_read_in_range, issue, rd_idx < CW'(CAPACITY), "read beyond store")

endmodule

`default_nettype wire
